FILE: rtl/core/snis_pkg.sv
package snis_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int POS_W = 4;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_SPLIT  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PART_LESSER  = 2'd0,
        PART_MIDDLE  = 2'd1,
        PART_GREATER = 2'd2
    } part_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } kv_t;

    typedef struct packed {
        logic             status;
        logic [POS_W-1:0] position;
        logic [KEY_W-1:0] out_key;
        logic [VAL_W-1:0] out_value;
        part_t            part;
        logic             last;
    } res_t;

endpackage

FILE: rtl/core/snis_mem.sv
module snis_mem #(
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  snis_pkg::kv_t   wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output snis_pkg::kv_t   rdata
);
    import snis_pkg::*;

    kv_t mem [DEPTH];
    kv_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/snis_seq.sv
module snis_seq #(
    parameter int NODE_SIZE = 8,
    localparam int IW = $clog2(NODE_SIZE)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  snis_pkg::action_t   in_action,
    input  logic [31:0]         in_key,
    input  logic [31:0]         in_value,
    output logic                res_valid,
    input  logic                res_ready,
    output snis_pkg::res_t      res,
    output logic                mem_we,
    output logic [IW-1:0]       mem_waddr,
    output snis_pkg::kv_t       mem_wdata,
    output logic                mem_re,
    output logic [IW-1:0]       mem_raddr,
    input  snis_pkg::kv_t       mem_rdata
);
    import snis_pkg::*;

    localparam int CW = $clog2(NODE_SIZE + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(NODE_SIZE);
    localparam logic [CW-1:0] MID      = CW'(NODE_SIZE / 2);
    localparam logic [CW-1:0] ONE      = CW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPL_RD,
        S_SPL_OUT,
        S_EMIT
    } state_t;

    state_t             state_reg,   state_next;
    action_t            op_reg,      op_next;
    logic [KEY_W-1:0]   key_reg,     key_next;
    logic [VAL_W-1:0]   val_reg,     val_next;
    logic [CW-1:0]      count_reg,   count_next;
    logic [CW-1:0]      idx_reg,     idx_next;
    logic [CW-1:0]      slot_reg,    slot_next;
    logic [CW-1:0]      out_idx_reg, out_idx_next;
    logic [CW-1:0]      src_reg,     src_next;
    logic               sel_new_reg, sel_new_next;
    logic               status_reg,  status_next;
    logic [CW-1:0]      rpos_reg,    rpos_next;

    // shared comparator: search wants stored < probe, insert/split stored <= probe
    logic               is_search;
    logic [KEY_W-1:0]   cmp_a, cmp_b;
    logic               cmp_lt, scan_go;

    assign is_search = (op_reg == ACT_SEARCH);
    assign cmp_a     = is_search ? mem_rdata.key : key_reg;
    assign cmp_b     = is_search ? key_reg : mem_rdata.key;
    assign cmp_lt    = (cmp_a < cmp_b);
    assign scan_go   = is_search ? cmp_lt : !cmp_lt;

    assign in_ready = (state_reg == S_IDLE);

    logic          scan_done;
    logic [CW-1:0] found;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        slot_next    = slot_reg;
        out_idx_next = out_idx_reg;
        src_next     = src_reg;
        sel_new_next = sel_new_reg;
        status_next  = status_reg;
        rpos_next    = rpos_reg;

        scan_done = 1'b0;
        found     = idx_reg;

        mem_we    = 1'b0;
        mem_waddr = idx_reg[IW-1:0];
        mem_wdata = '{key: key_reg, value: val_reg};
        mem_re    = 1'b0;
        mem_raddr = idx_reg[IW-1:0];

        res_valid     = 1'b0;
        res.status    = status_reg;
        res.position  = POS_W'(rpos_reg);
        res.out_key   = '0;
        res.out_value = '0;
        res.part      = PART_LESSER;
        res.last      = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_action;
                    key_next    = in_key;
                    val_next    = in_value;
                    status_next = 1'b0;
                    idx_next    = '0;
                    unique case (in_action)
                        ACT_INSERT:
                        begin
                            if (count_reg >= FULL_CNT)
                            begin
                                status_next = 1'b1;
                                rpos_next   = count_reg;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            rpos_next  = '0;
                            state_next = S_EMIT;
                        end
                        ACT_SPLIT:
                        begin
                            if (count_reg != FULL_CNT)
                            begin
                                status_next = 1'b1;
                                rpos_next   = count_reg;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    scan_done = 1'b1;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg[IW-1:0];
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (scan_go)
                begin
                    idx_next   = idx_reg + ONE;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    scan_done = 1'b1;
                end
            end

            S_SHIFT_RD:
            begin
                if (idx_reg == slot_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_reg[IW-1:0];
                    if (op_reg == ACT_INSERT)
                    begin
                        count_next = count_reg + ONE;
                        rpos_next  = count_reg + ONE;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        count_next = MID;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = 
                        IW'(idx_reg - ONE);
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[IW-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = idx_reg - ONE;
                state_next = S_SHIFT_RD;
            end

            S_SPL_RD:
            begin
                if (out_idx_reg == slot_reg)
                begin
                    sel_new_next = 1'b1;
                end
                else
                begin
                    sel_new_next = 1'b0;
                    mem_re       = 1'b1;
                    mem_raddr    = src_reg[IW-1:0];
                end
                state_next = S_SPL_OUT;
            end

            S_SPL_OUT:
            begin
                res_valid     = 1'b1;
                res.status    = 1'b0;
                res.position  = '0;
                res.out_key   = sel_new_reg ? key_reg : mem_rdata.key;
                res.out_value = sel_new_reg ? val_reg : mem_rdata.value;
                if (out_idx_reg < MID)
                begin
                    res.part = PART_LESSER;
                end
                else if (out_idx_reg == MID)
                begin
                    res.part = PART_MIDDLE;
                end
                else
                begin
                    res.part = PART_GREATER;
                end
                res.last = (out_idx_reg == FULL_CNT);
                if (res_ready)
                begin
                    if (out_idx_reg == FULL_CNT)
                    begin
                        // lower half only changes when the new pair landed in it
                        if (slot_reg < MID)
                        begin
                            idx_next   = MID - ONE;
                            state_next = S_SHIFT_RD;
                        end
                        else
                        begin
                            count_next = MID;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + ONE;
                        if (!sel_new_reg)
                        begin
                            src_next = src_reg + ONE;
                        end
                        state_next = S_SPL_RD;
                    end
                end
            end

            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (scan_done)
        begin
            slot_next = found;
            unique case (op_reg)
                ACT_SEARCH:
                begin
                    rpos_next  = found;
                    state_next = S_EMIT;
                end
                ACT_INSERT:
                begin
                    idx_next   = count_reg;
                    state_next = S_SHIFT_RD;
                end
                default:
                begin
                    out_idx_next = '0;
                    src_next     = '0;
                    state_next   = S_SPL_RD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= ACT_INSERT;
            key_reg     <= '0;
            val_reg     <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            slot_reg    <= '0;
            out_idx_reg <= '0;
            src_reg     <= '0;
            sel_new_reg <= 1'b0;
            status_reg  <= 1'b0;
            rpos_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            key_reg     <= key_next;
            val_reg     <= val_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            slot_reg    <= slot_next;
            out_idx_reg <= out_idx_next;
            src_reg     <= src_next;
            sel_new_reg <= sel_new_next;
            status_reg  <= status_next;
            rpos_reg    <= rpos_next;
        end
    end

endmodule

FILE: rtl/core/sorted_node_insert_search_split_top.sv
// Channel | Dir | tdata (low bit up)                           | tuser   | tlast
// s_*     | in  | key[31:0], value[63:32]                      | action  | -
// m_*     | out | status[0], position[4:1], out_key[36:5],     | part    | last
//         |     | out_value[68:37], zero[71:69]                |         |
// One transaction in at a time; s_tready is high only while the sequencer is idle.
// Scan: keys are compared one at a time (one comparator, registered read).
// Search emits after the scan; insert scans, then shifts entries up one by one; clear and rejects skip the scan.
// Split: scan, then emit NODE_SIZE+1 pairs; the lower half is shifted if the new pair lands low.
// m_tready low stalls the sequencer on its next result; reset empties the node.
module sorted_node_insert_search_split_top #(
    parameter int NODE_SIZE = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // key, value
    input  logic [1:0]  s_tuser,    // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // status, position, out_key, out_value, pad
    output logic [1:0]  m_tuser,    // part
    output logic        m_tlast
);
    import snis_pkg::*;

    localparam int IW = $clog2(NODE_SIZE);

    res_t          res;
    logic          res_valid, res_ready;
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    kv_t           mem_wdata, mem_rdata;

    res_t          out_reg;
    logic          out_valid_reg;

    snis_seq #(
        .NODE_SIZE (NODE_SIZE)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (action_t'(s_tuser)),
        .in_key    (s_tdata[31:0]),
        .in_value  (s_tdata[63:32]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    snis_mem #(
        .DEPTH (NODE_SIZE)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
            begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.out_value, out_reg.out_key,
                       out_reg.position, out_reg.status};
    assign m_tuser  = out_reg.part;
    assign m_tlast  = out_reg.last;

endmodule
